// File: hw/rtl/polygon_perimeter_macros.svh
// Assertion macros shared by the polygon perimeter RTL.
`ifndef POLYGON_PERIMETER_MACROS_SVH
`define POLYGON_PERIMETER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define PP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/polyper_pkg.sv
// Shared constants for the polygon perimeter block.
package polyper_pkg;

  localparam int unsigned SUM_BITS = 40;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

endpackage

// File: hw/rtl/polygon_perimeter.sv
// Vertices: the first vertex of a longer polygon is taken with no stall; a lone vertex stalls
// the input while its result loads into the output register. Any other vertex runs the
// bit-serial square (one multiplier bit a cycle) and then the digit-by-digit root (one root bit
// a cycle), then adds the root to the sum.
// A last vertex runs the closing edge too, then loads the result once the output register is free.
// Throughput: one vertex at a time; the next is taken as soon as the edge work ends.
// Reset: asynchronous, clears the polygon state, the sequencer and the output valid.
`include "polygon_perimeter_macros.svh"

module polygon_perimeter #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_BITS-1:0]         x_coord_i,
  input  logic signed [COORD_BITS-1:0]         y_coord_i,
  input  logic                                 last_vertex_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [polyper_pkg::SUM_BITS-1:0]     perimeter_o,
  output logic                                 overflowed_o
);
  import polyper_pkg::*;

  // radicand = (dx^2 + dy^2) << 2*FRAC_BITS, padded to an even width
  localparam int unsigned SQ_BITS   = 2 * COORD_BITS + 1;
  localparam int unsigned RAD_RAW   = SQ_BITS + 2 * FRAC_BITS;
  localparam int unsigned RAD_BITS  = RAD_RAW + (RAD_RAW % 2);
  localparam int unsigned ROOT_BITS = RAD_BITS / 2;
  localparam int unsigned REM_BITS  = ROOT_BITS + 2;
  localparam int unsigned CNT_BITS  = $clog2(ROOT_BITS + 1);
  localparam int unsigned EXT_BITS  = ((ROOT_BITS > SUM_BITS) ? ROOT_BITS : SUM_BITS) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_ADD,
    ST_CLOSE,
    ST_OUT
  } state_e;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                    input logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    begin
      d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
      m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
      abs_diff = m[COORD_BITS-1:0];
    end
  endfunction

  state_e                         state_q;
  logic                           have_first_q;
  logic                           last_q;
  logic                           close_pend_q;
  logic signed [COORD_BITS-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [SUM_BITS-1:0]            sum_q;
  logic                           sat_q;
  logic [COORD_BITS-1:0]          mx_q, my_q;
  logic [SQ_BITS-1:0]             cx_q, cy_q, acc_q;
  logic [RAD_BITS-1:0]            rad_q;
  logic [REM_BITS-1:0]            rem_q;
  logic [ROOT_BITS-1:0]           root_q;
  logic [CNT_BITS-1:0]            cnt_q;
  logic                           out_valid_q;
  logic                           out_ovf_q;
  logic [SUM_BITS-1:0]            out_perim_q;

  logic                           in_take;
  logic                           out_take;
  logic [COORD_BITS-1:0]          dx_new, dy_new, dx_close, dy_close;
  logic [SQ_BITS-1:0]             acc_d;
  logic [REM_BITS-1:0]            rem_sh, trial;
  logic                           root_bit;
  logic [EXT_BITS-1:0]            sum_ext;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_take      = in_valid_i && !in_stall_o;
  assign out_take     = out_valid_q && !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign perimeter_o  = out_perim_q;
  assign overflowed_o = out_ovf_q;

  assign dx_new   = abs_diff(x_coord_i, prev_x_q);
  assign dy_new   = abs_diff(y_coord_i, prev_y_q);
  assign dx_close = abs_diff(prev_x_q, first_x_q);
  assign dy_close = abs_diff(prev_y_q, first_y_q);

  // one multiplier bit of each square per cycle
  assign acc_d = acc_q + (mx_q[0] ? cx_q : '0) + (my_q[0] ? cy_q : '0);

  // one root bit per cycle: bring down two radicand bits, try root*4+1
  assign rem_sh   = {rem_q[ROOT_BITS-1:0], rad_q[RAD_BITS-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign root_bit = (rem_sh >= trial);

  assign sum_ext = EXT_BITS'(sum_q) + EXT_BITS'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      have_first_q <= 1'b0;
      last_q       <= 1'b0;
      close_pend_q <= 1'b0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      sum_q        <= '0;
      sat_q        <= 1'b0;
      mx_q         <= '0;
      my_q         <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      acc_q        <= '0;
      rad_q        <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_ovf_q    <= 1'b0;
      out_perim_q  <= '0;
    end else begin
      // the result state sets the valid itself
      if (out_take && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            prev_x_q     <= x_coord_i;
            prev_y_q     <= y_coord_i;
            last_q       <= last_vertex_i;
            close_pend_q <= last_vertex_i;
            if (!have_first_q) begin
              first_x_q    <= x_coord_i;
              first_y_q    <= y_coord_i;
              have_first_q <= 1'b1;
              // a lone vertex closes on itself with length zero
              state_q      <= last_vertex_i ? ST_OUT : ST_IDLE;
            end else begin
              mx_q    <= dx_new;
              my_q    <= dy_new;
              cx_q    <= SQ_BITS'(dx_new);
              cy_q    <= SQ_BITS'(dy_new);
              acc_q   <= '0;
              cnt_q   <= CNT_BITS'(COORD_BITS);
              state_q <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          acc_q <= acc_d;
          mx_q  <= mx_q >> 1;
          my_q  <= my_q >> 1;
          cx_q  <= cx_q << 1;
          cy_q  <= cy_q << 1;
          if (cnt_q == CNT_BITS'(1)) begin
            rad_q   <= RAD_BITS'(acc_d) << (2 * FRAC_BITS);
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= CNT_BITS'(ROOT_BITS);
            state_q <= ST_ROOT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_ROOT: begin
          rad_q  <= rad_q << 2;
          rem_q  <= root_bit ? (rem_sh - trial) : rem_sh;
          root_q <= {root_q[ROOT_BITS-2:0], root_bit};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CNT_BITS'(1)) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          // saturate at the top of the sum and stick there
          if (sum_ext > EXT_BITS'(SUM_MAX)) begin
            sum_q <= SUM_MAX;
            sat_q <= 1'b1;
          end else begin
            sum_q <= sum_ext[SUM_BITS-1:0];
          end
          if (close_pend_q) begin
            state_q <= ST_CLOSE;
          end else if (last_q) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_CLOSE: begin
          close_pend_q <= 1'b0;
          mx_q         <= dx_close;
          my_q         <= dy_close;
          cx_q         <= SQ_BITS'(dx_close);
          cy_q         <= SQ_BITS'(dy_close);
          acc_q        <= '0;
          cnt_q        <= CNT_BITS'(COORD_BITS);
          state_q      <= ST_SQR;
        end
        ST_OUT: begin
          // hold until the output register is free, then drop the polygon state
          if (!out_valid_q || out_take) begin
            out_valid_q  <= 1'b1;
            out_perim_q  <= sum_q;
            out_ovf_q    <= sat_q;
            have_first_q <= 1'b0;
            last_q       <= 1'b0;
            close_pend_q <= 1'b0;
            first_x_q    <= '0;
            first_y_q    <= '0;
            prev_x_q     <= '0;
            prev_y_q     <= '0;
            sum_q        <= '0;
            sat_q        <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `PP_ASSERT_NOW(a_ovf_means_max, clk_i, rst_ni, out_valid_o && overflowed_o, perimeter_o == SUM_MAX, "overflow flag without saturated perimeter")
  `PP_ASSERT_NOW(a_sat_sticks, clk_i, rst_ni, sat_q, sum_q == SUM_MAX, "saturated sum left its maximum")
  `PP_ASSERT_NOW(a_fresh_polygon, clk_i, rst_ni, !have_first_q, (sum_q == '0) && !sat_q, "sum not cleared before first vertex")
  `PP_ASSERT_NEXT(a_root_to_add, clk_i, rst_ni, (state_q == ST_ROOT) && (cnt_q == CNT_BITS'(1)), state_q == ST_ADD, "root did not finish into accumulate")

endmodule
